// ----- hdl/lchc_pkg.sv -----
// Package for the LRU cache hit cost counter.
// Holds default sizes, cost and character constants, the controller state
// type and the command and status structs shared by controller and datapath.
package lchc_pkg;

  localparam int unsigned ENTRIES_DEF   = 32;
  localparam int unsigned KEY_BYTES_DEF = 8;
  localparam int unsigned KEY_IN_W      = 64;
  localparam int unsigned SIZE_W        = 6;
  localparam int unsigned COST_W        = 3;
  localparam int unsigned SUM_W         = 32;

  localparam logic [COST_W-1:0] HIT_COST  = 3'd1;
  localparam logic [COST_W-1:0] MISS_COST = 3'd5;

  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_SRD,
    ST_SWR,
    ST_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic rd_search;
    logic rd_next;
    logic idx_clr;
    logic idx_inc;
    logic set_hit;
    logic wr_shift;
    logic wr_key;
  } cmd_t;

  typedef struct packed {
    logic search_end;
    logic match;
    logic shift_end;
    logic cap_zero;
    logic full;
  } sts_t;

endpackage

// ----- hdl/lchc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Stands alone; used for the recency-ordered tag store.
module lchc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/lchc_ctrl.sv -----
// Controller state machine for the LRU cache hit cost counter.
// Depends on lchc_pkg for the state type and the command and status structs.
module lchc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  lchc_pkg::sts_t sts_i,
  output lchc_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o
);

  lchc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lchc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      lchc_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = lchc_pkg::ST_RD;
        end
      end
      lchc_pkg::ST_RD: begin
        if (sts_i.search_end) begin
          if (sts_i.cap_zero) begin
            state_d = lchc_pkg::ST_WR;
          end else if (sts_i.full) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = lchc_pkg::ST_SRD;
          end else begin
            state_d = lchc_pkg::ST_WR;
          end
        end else begin
          cmd_o.rd_search = 1'b1;
          state_d         = lchc_pkg::ST_CMP;
        end
      end
      lchc_pkg::ST_CMP: begin
        if (sts_i.match) begin
          cmd_o.set_hit = 1'b1;
          state_d       = lchc_pkg::ST_SRD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = lchc_pkg::ST_RD;
        end
      end
      lchc_pkg::ST_SRD: begin
        if (sts_i.shift_end) begin
          state_d = lchc_pkg::ST_WR;
        end else begin
          cmd_o.rd_next = 1'b1;
          state_d       = lchc_pkg::ST_SWR;
        end
      end
      lchc_pkg::ST_SWR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d        = lchc_pkg::ST_SRD;
      end
      lchc_pkg::ST_WR: begin
        cmd_o.wr_key = 1'b1;
        state_d      = lchc_pkg::ST_DONE;
      end
      lchc_pkg::ST_DONE: begin
        done_o  = 1'b1;
        state_d = lchc_pkg::ST_IDLE;
      end
      default: begin
        state_d = lchc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/lchc_dp.sv -----
// Datapath for the LRU cache hit cost counter: key folding, size and count
// registers, the tag RAM with its index counter, and the saturating cost sum.
// Depends on lchc_pkg and lchc_ram.
module lchc_dp #(
  parameter int unsigned ENTRIES   = lchc_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BYTES = lchc_pkg::KEY_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lchc_pkg::KEY_IN_W-1:0]  key_i,
  input  logic                           cfg_valid_i,
  input  logic [lchc_pkg::SIZE_W-1:0]    cfg_data_i,
  input  lchc_pkg::cmd_t                 cmd_i,
  output lchc_pkg::sts_t                 sts_o,
  output logic                           hit_o,
  output logic [lchc_pkg::COST_W-1:0]    cost_o,
  output logic [lchc_pkg::SUM_W-1:0]     total_cost_o
);

  localparam int unsigned KEY_W = 8 * KEY_BYTES;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CMP_W = (CNT_W > lchc_pkg::SIZE_W) ? CNT_W : lchc_pkg::SIZE_W;

  logic [KEY_W-1:0]                key_fold;
  logic [KEY_W-1:0]                key_q;
  logic [lchc_pkg::SIZE_W-1:0]     size_q;
  logic [CNT_W-1:0]                count_q, count_d;
  logic [CNT_W-1:0]                idx_q, idx_d;
  logic                            hit_q, hit_d;
  logic [lchc_pkg::SUM_W-1:0]      sum_q, sum_d;
  logic [CNT_W-1:0]                cap;
  logic [CNT_W-1:0]                n_eff;
  logic [CNT_W:0]                  idx_plus;
  logic [lchc_pkg::SUM_W:0]        sum_ext;
  logic [lchc_pkg::COST_W-1:0]     cost;
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [KEY_W-1:0]                ram_wdata;
  logic                            ram_re;
  logic [AW-1:0]                   ram_raddr;
  logic [KEY_W-1:0]                ram_rdata;

  // Lower-case letters are folded to upper case, byte by byte.
  always_comb begin
    logic [7:0] ch;
    for (int b = 0; b < KEY_BYTES; b++) begin
      ch = key_i[8*b +: 8];
      if (ch >= lchc_pkg::CHAR_LOWER_A && ch <= lchc_pkg::CHAR_LOWER_Z) begin
        ch = ch - lchc_pkg::CHAR_LOWER_A + lchc_pkg::CHAR_UPPER_A;
      end
      key_fold[8*b +: 8] = ch;
    end
  end

  always_comb begin
    if (CMP_W'(size_q) > CMP_W'(ENTRIES)) begin
      cap = CNT_W'(ENTRIES);
    end else begin
      cap = CNT_W'(size_q);
    end
    n_eff = (count_q > cap) ? cap : count_q;
  end

  assign idx_plus = {1'b0, idx_q} + {{CNT_W{1'b0}}, 1'b1};
  assign cost     = hit_q ? lchc_pkg::HIT_COST : lchc_pkg::MISS_COST;

  always_comb begin
    sts_o.search_end = (idx_q == n_eff);
    sts_o.match      = (ram_rdata == key_q);
    sts_o.shift_end  = (idx_plus >= {1'b0, n_eff});
    sts_o.cap_zero   = (cap == '0);
    sts_o.full       = (n_eff == cap);
  end

  always_comb begin
    idx_d   = idx_q;
    hit_d   = hit_q;
    count_d = count_q;
    sum_d   = sum_q;
    sum_ext = {1'b0, sum_q} + (lchc_pkg::SUM_W + 1)'(cost);
    if (cmd_i.load) begin
      idx_d = '0;
      hit_d = 1'b0;
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end
    if (cmd_i.idx_inc) begin
      idx_d = idx_plus[CNT_W-1:0];
    end
    if (cmd_i.set_hit) begin
      hit_d = 1'b1;
    end
    if (cmd_i.wr_key) begin
      count_d = (cap == '0) ? '0 : idx_plus[CNT_W-1:0];
      sum_d   = sum_ext[lchc_pkg::SUM_W] ? '1 : sum_ext[lchc_pkg::SUM_W-1:0];
    end
    if (cfg_valid_i) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
      hit_q   <= 1'b0;
      sum_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        size_q <= cfg_data_i;
      end
      count_q <= count_d;
      idx_q   <= idx_d;
      hit_q   <= hit_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_fold;
    end
  end

  always_comb begin
    ram_re    = cmd_i.rd_search | cmd_i.rd_next;
    ram_raddr = cmd_i.rd_next ? idx_plus[AW-1:0] : idx_q[AW-1:0];
    ram_we    = cmd_i.wr_shift | (cmd_i.wr_key & (cap != '0));
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = cmd_i.wr_shift ? ram_rdata : key_q;
  end

  lchc_ram #(
    .WIDTH (KEY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign hit_o        = hit_q;
  assign cost_o       = cost;
  assign total_cost_o = sum_q;

endmodule

// ----- hdl/lru_cache_hit_cost_counter.sv -----
// Top level of the LRU cache hit cost counter.
// Instantiates lchc_ctrl and lchc_dp; depends on lchc_pkg.
//
// An item is taken when start is high while busy is low, and its single result
// appears on hit_o, cost_o and total_cost_o for exactly one cycle with done_o
// high; the receiver cannot stall, so it must take the result in that cycle.
// The tag store is one RAM with a registered read port, searched one entry at a
// time with a read and a compare state per entry; on a hit, or on a miss with the
// store full, the entries above are then shifted down one at a time with a read
// and a write state per entry. With a cache size of zero nothing is searched or
// stored. busy falls in the cycle after done_o, so the next item can be taken in
// the cycle after the result. Writing the size register empties the store and
// leaves the running cost untouched; cfg_ready_o is always high.
module lru_cache_hit_cost_counter #(
  parameter int unsigned ENTRIES   = lchc_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BYTES = lchc_pkg::KEY_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [lchc_pkg::KEY_IN_W-1:0] key_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lchc_pkg::SIZE_W-1:0]   cfg_data_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [lchc_pkg::COST_W-1:0]   cost_o,
  output logic [lchc_pkg::SUM_W-1:0]    total_cost_o
);

  lchc_pkg::cmd_t cmd;
  lchc_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  lchc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  lchc_dp #(
    .ENTRIES   (ENTRIES),
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_i        (key_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .hit_o        (hit_o),
    .cost_o       (cost_o),
    .total_cost_o (total_cost_o)
  );

endmodule

// ----- hdl/lchc_checker.sv -----
// Port-level checker for the LRU cache hit cost counter, bound to the top level.
// Depends on lchc_pkg for the cost constants.
module lchc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic                          hit_o,
  input logic [lchc_pkg::COST_W-1:0]   cost_o,
  input logic [lchc_pkg::SUM_W-1:0]    total_cost_o
);

  // A result only ever closes an item that was being worked on.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without an item in progress");

  a_cost_matches_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((hit_o && cost_o == lchc_pkg::HIT_COST) ||
                (!hit_o && cost_o == lchc_pkg::MISS_COST)))
    else $error("cost does not match hit flag");

  a_accept_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // Each item gives exactly one result, after which the block is free again.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("result repeated or block still busy after result");

  // The running total includes the cost of the item being reported.
  a_total_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (total_cost_o != '0))
    else $error("running total is zero on a result");

endmodule

bind lru_cache_hit_cost_counter lchc_checker u_lchc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .hit_o        (hit_o),
  .cost_o       (cost_o),
  .total_cost_o (total_cost_o)
);

// ----- sim/lru_cache_hit_cost_counter_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lru_cache_hit_cost_counter: an LRU tag store
// model predicts hit, cost and running total for every key. Uses lchc_pkg.
module lru_cache_hit_cost_counter_tb;

  localparam int unsigned       KEY_IN_W      = lchc_pkg::KEY_IN_W;
  localparam int unsigned       SIZE_W        = lchc_pkg::SIZE_W;
  localparam int unsigned       COST_W        = lchc_pkg::COST_W;
  localparam int unsigned       SUM_W         = lchc_pkg::SUM_W;
  localparam int unsigned       KEY_BYTES_DEF = lchc_pkg::KEY_BYTES_DEF;
  localparam logic [COST_W-1:0] HIT_COST      = lchc_pkg::HIT_COST;
  localparam logic [COST_W-1:0] MISS_COST     = lchc_pkg::MISS_COST;
  localparam logic [7:0]        CHAR_LOWER_A  = lchc_pkg::CHAR_LOWER_A;
  localparam logic [7:0]        CHAR_LOWER_Z  = lchc_pkg::CHAR_LOWER_Z;
  localparam logic [7:0]        CHAR_UPPER_A  = lchc_pkg::CHAR_UPPER_A;

  localparam int unsigned SLOTS          = lchc_pkg::ENTRIES_DEF;
  localparam int unsigned RANDOM_KEYS    = 550;
  localparam int unsigned DRAIN_CYCLES   = 4 * SLOTS + 40;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic                is_size;
    logic [KEY_IN_W-1:0] key;
    logic [SIZE_W-1:0]   size;
  } lookup_t;

  typedef struct {
    logic              hit;
    logic [COST_W-1:0] cost;
    logic [SUM_W-1:0]  total;
  } outcome_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [KEY_IN_W-1:0] key_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [SIZE_W-1:0]   cfg_data_i;
  logic                done_o;
  logic                hit_o;
  logic [COST_W-1:0]   cost_o;
  logic [SUM_W-1:0]    total_cost_o;

  lookup_t  lookup_q[$];
  outcome_t outcome_q[$];

  logic [KEY_IN_W-1:0] lru_tags[SLOTS];
  int unsigned         held;
  logic [SIZE_W-1:0]   size_reg;
  logic [SUM_W-1:0]    cost_total;

  int unsigned gap_left;
  logic        no_idle;
  int unsigned quiet_cycles;
  logic        mismatch_seen;

  lru_cache_hit_cost_counter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .key_i        (key_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .hit_o        (hit_o),
    .cost_o       (cost_o),
    .total_cost_o (total_cost_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic logic [KEY_IN_W-1:0] fold_upper(input logic [KEY_IN_W-1:0] raw);
    logic [KEY_IN_W-1:0] folded;
    logic [7:0]          ch;
    folded = '0;
    for (int b = 0; b < KEY_BYTES_DEF; b++) begin
      ch = raw[8*b +: 8];
      if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
        ch = ch - CHAR_LOWER_A + CHAR_UPPER_A;
      end
      folded[8*b +: 8] = ch;
    end
    return folded;
  endfunction

  task automatic access_cache(input logic [KEY_IN_W-1:0] raw);
    logic [KEY_IN_W-1:0] tag;
    int unsigned         limit;
    int unsigned         n;
    int                  pos;
    outcome_t            res;
    logic [SUM_W:0]      sum;
    tag   = fold_upper(raw);
    limit = (size_reg > SLOTS) ? SLOTS : size_reg;
    n     = (held > limit) ? limit : held;
    pos   = -1;
    for (int i = 0; i < n; i++) begin
      if (pos < 0 && lru_tags[i] == tag) begin
        pos = i;
      end
    end
    if (pos >= 0) begin
      for (int i = pos; i + 1 < n; i++) begin
        lru_tags[i] = lru_tags[i + 1];
      end
      lru_tags[n - 1] = tag;
      res.hit  = 1'b1;
      res.cost = HIT_COST;
    end else begin
      if (limit > 0) begin
        if (n >= limit) begin
          for (int i = 0; i + 1 < n; i++) begin
            lru_tags[i] = lru_tags[i + 1];
          end
          n = limit - 1;
        end
        lru_tags[n] = tag;
        n++;
      end
      res.hit  = 1'b0;
      res.cost = MISS_COST;
    end
    held = n;
    sum  = {1'b0, cost_total} + res.cost;
    cost_total = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
    res.total  = cost_total;
    outcome_q.insert(outcome_q.size(), res);
  endtask

  function automatic logic [KEY_IN_W-1:0] make_name();
    logic [KEY_IN_W-1:0] name;
    int unsigned         len;
    name = '0;
    len  = $urandom_range(1, KEY_BYTES_DEF);
    for (int b = 0; b < len; b++) begin
      if ($urandom_range(0, 99) < 85) begin
        name[8*b +: 8] = CHAR_UPPER_A + 8'($urandom_range(0, 25));
      end else begin
        name[8*b +: 8] = 8'($urandom_range(0, 255));
      end
    end
    return name;
  endfunction

  function automatic logic [KEY_IN_W-1:0] scramble_case(input logic [KEY_IN_W-1:0] name);
    logic [KEY_IN_W-1:0] mixed;
    logic [7:0]          ch;
    mixed = name;
    for (int b = 0; b < KEY_BYTES_DEF; b++) begin
      ch = name[8*b +: 8];
      if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_A + 8'd25 && $urandom_range(0, 1) == 1) begin
        mixed[8*b +: 8] = ch - CHAR_UPPER_A + CHAR_LOWER_A;
      end
    end
    return mixed;
  endfunction

  task automatic queue_key(input logic [KEY_IN_W-1:0] key);
    lookup_t item;
    item.is_size = 1'b0;
    item.key     = key;
    item.size    = '0;
    lookup_q.insert(lookup_q.size(), item);
  endtask

  task automatic queue_size(input logic [SIZE_W-1:0] size);
    lookup_t item;
    item.is_size = 1'b1;
    item.key     = '0;
    item.size    = size;
    lookup_q.insert(lookup_q.size(), item);
  endtask

  // Driver: takes items from lookup_q and keeps the predictor in step with
  // every accepted key and size write.
  always @(posedge clk_i or negedge rst_ni) begin
    logic bus_free;
    logic just_taken;
    if (!rst_ni) begin
      start       <= 1'b0;
      key_i       <= '0;
      cfg_valid_i <= 1'b0;
      cfg_data_i  <= '0;
      gap_left    <= 0;
      no_idle     <= 1'b0;
      held        = 0;
      size_reg    = '0;
      cost_total  = '0;
    end else begin
      bus_free   = 1'b1;
      just_taken = 1'b0;
      if (start) begin
        if (!busy) begin
          access_cache(key_i);
          just_taken = 1'b1;
        end else begin
          bus_free = 1'b0;
        end
      end
      if (cfg_valid_i) begin
        if (cfg_ready_o) begin
          size_reg = cfg_data_i;
          held     = 0;
        end else begin
          bus_free = 1'b0;
        end
      end
      if (bus_free) begin
        if (gap_left != 0) begin
          gap_left    <= gap_left - 1;
          start       <= 1'b0;
          cfg_valid_i <= 1'b0;
        end else if (lookup_q.size() == 0) begin
          start       <= 1'b0;
          cfg_valid_i <= 1'b0;
        end else if (lookup_q[0].is_size) begin
          start <= 1'b0;
          // The size is only changed once the store has gone quiet.
          if (outcome_q.size() == 0 && !busy && !done_o && !just_taken) begin
            cfg_valid_i <= 1'b1;
            cfg_data_i  <= lookup_q[0].size;
            void'(lookup_q.pop_front());
            gap_left    <= no_idle ? 0 : $urandom_range(0, 13);
          end else begin
            cfg_valid_i <= 1'b0;
          end
        end else begin
          cfg_valid_i <= 1'b0;
          start       <= 1'b1;
          key_i       <= lookup_q[0].key;
          void'(lookup_q.pop_front());
          if ($urandom_range(0, 29) == 0) begin
            no_idle <= !no_idle;
          end
          gap_left <= no_idle ? 0 : $urandom_range(0, 13);
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      mismatch_seen <= 1'b0;
    end else if (done_o) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: result with none expected, got hit %0d cost %0d total %0d",
                 $time, hit_o, cost_o, total_cost_o);
        mismatch_seen <= 1'b1;
      end else begin
        want = outcome_q.pop_front();
        if (hit_o !== want.hit) begin
          $display("%0t: hit mismatch, expected %0d, got %0d", $time, want.hit, hit_o);
          mismatch_seen <= 1'b1;
        end
        if (cost_o !== want.cost) begin
          $display("%0t: cost mismatch, expected %0d, got %0d", $time, want.cost, cost_o);
          mismatch_seen <= 1'b1;
        end
        if (total_cost_o !== want.total) begin
          $display("%0t: total_cost mismatch, expected %0d, got %0d",
                   $time, want.total, total_cost_o);
          mismatch_seen <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [KEY_IN_W-1:0] pool[64];
    int unsigned         pool_n;
    int unsigned         cap;
    int unsigned         run_len;
    int unsigned         sent;
    int unsigned         pick;
    logic [SIZE_W-1:0]   size;

    rst_ni = 1'b0;

    // Size zero straight after reset, including the all-zero key twice.
    queue_key('0);
    queue_key('0);
    queue_key('1);
    // Two entries: folding, recency move on a hit and eviction order.
    queue_size(6'd2);
    queue_key(64'h0000_0000_0063_6261);
    queue_key(64'h0000_0000_0000_0078);
    queue_key(64'h0000_0000_0043_4241);
    queue_key(64'h0000_0000_0000_0071);
    queue_key(64'h0000_0000_0000_0078);
    queue_key(64'h0000_0000_0063_6261);
    // Largest size setting: capacity limited to the number of slots.
    queue_size(6'd63);
    queue_key('1);
    queue_key('0);
    queue_key(64'h0000_0041_0000_4200);
    queue_key(64'h0000_0061_0000_6200);
    queue_key(64'h0000_0000_5B40_7B60);
    queue_key(64'h0000_0000_7A61_5A41);
    queue_key(64'h0000_0000_7A61_7A61);
    queue_key(64'h8000_0000_0000_0000);
    // One entry.
    queue_size(6'd1);
    queue_key(64'h0000_0000_0000_0035);
    queue_key(64'h0000_0000_0000_0035);
    queue_key(64'h0000_0000_0000_0036);
    queue_key(64'h0000_0000_0000_0035);
    queue_size(6'd33);
    queue_key(64'hFFFF_FFFF_FFFF_FFFF);
    queue_key(64'h7A7A_7A7A_7A7A_7A7A);
    queue_key(64'h5A5A_5A5A_5A5A_5A5A);
    queue_size(6'd0);
    queue_key(64'h0000_0000_0000_0041);

    sent = 0;
    while (sent < RANDOM_KEYS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: size = 6'd0;
        1: size = 6'd1;
        2, 3, 4, 5: size = 6'($urandom_range(2, 8));
        6, 7: size = 6'($urandom_range(9, 31));
        8: size = 6'd32;
        default: size = 6'($urandom_range(33, 63));
      endcase
      queue_size(size);
      cap    = (size > SLOTS) ? SLOTS : size;
      pool_n = $urandom_range(1, cap + cap / 2 + 2);
      if (pool_n > 64) begin
        pool_n = 64;
      end
      for (int p = 0; p < pool_n; p++) begin
        pool[p] = make_name();
      end
      run_len = $urandom_range(10, 50);
      for (int j = 0; j < run_len && sent < RANDOM_KEYS; j++) begin
        if ($urandom_range(0, 9) < 8) begin
          queue_key(scramble_case(pool[$urandom_range(0, pool_n - 1)]));
        end else begin
          queue_key({$urandom, $urandom});
        end
        sent++;
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (lookup_q.size() != 0 || outcome_q.size() != 0 || start || cfg_valid_i) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (!mismatch_seen && outcome_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
